// ----- src/tfn_pkg.sv -----
// package for the triangle face normal block
// widths, the cell transaction type and shared constants; no dependencies
package tfn_pkg;

	localparam int COORD_BITS       = 24;
	localparam int NORMAL_FRAC_BITS = 30;
	localparam int NORMAL_W         = 32;
	localparam int LANES            = 3;

	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = PROD_W;
	localparam int HALF_W  = MAG_W / 2;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int Q_W     = NORMAL_FRAC_BITS + 1;
	localparam int TW      = SUM_W + 2 * Q_W + 1;
	localparam int CELLS   = Q_W;

	localparam logic signed [NORMAL_W-1:0] NORM_ONE = NORMAL_W'(1) << NORMAL_FRAC_BITS;

	typedef logic [TW-1:0] wide_t;

	typedef struct packed {
		logic                        deg;
		logic [LANES-1:0]            neg;
		wide_t                       sb;
		wide_t [LANES-1:0]           d;
		wide_t [LANES-1:0]           rb;
		logic [LANES-1:0][Q_W-1:0]   q;
	} cell_t;

endpackage

// ----- src/tfn_front.sv -----
// front pipeline: edge vectors, cross product, squares and squared length
// depends on tfn_pkg; feeds the first normalization cell
module tfn_front (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   a_x,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   a_y,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   a_z,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   b_x,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   b_y,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   b_z,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   c_x,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   c_y,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]   c_z,
	output logic                                    out_valid,
	output tfn_pkg::cell_t                          out_data
);

	logic signed [tfn_pkg::COORD_BITS-1:0] av [tfn_pkg::LANES];
	logic signed [tfn_pkg::COORD_BITS-1:0] bv [tfn_pkg::LANES];
	logic signed [tfn_pkg::COORD_BITS-1:0] cv [tfn_pkg::LANES];

	logic signed [tfn_pkg::DIFF_W-1:0]  u_s1 [tfn_pkg::LANES];
	logic signed [tfn_pkg::DIFF_W-1:0]  v_s1 [tfn_pkg::LANES];
	logic signed [tfn_pkg::PROD_W-1:0]  p_s2 [tfn_pkg::LANES];
	logic signed [tfn_pkg::PROD_W-1:0]  r_s2 [tfn_pkg::LANES];
	logic signed [tfn_pkg::CROSS_W-1:0] n_c  [tfn_pkg::LANES];
	logic [tfn_pkg::MAG_W-1:0]          mag_s3 [tfn_pkg::LANES];
	logic [tfn_pkg::LANES-1:0]          neg_s3, neg_s4, neg_s5, neg_s6;
	logic [2*tfn_pkg::HALF_W-1:0]       hh_s4 [tfn_pkg::LANES];
	logic [2*tfn_pkg::HALF_W-1:0]       hl_s4 [tfn_pkg::LANES];
	logic [2*tfn_pkg::HALF_W-1:0]       ll_s4 [tfn_pkg::LANES];
	logic [tfn_pkg::SQ_W-1:0]           sq_s5 [tfn_pkg::LANES];
	logic [tfn_pkg::SQ_W-1:0]           sq_s6 [tfn_pkg::LANES];
	logic [tfn_pkg::SUM_W-1:0]          sum_s6;
	logic [5:0]                         vld_q;

	assign av[0] = a_x; assign av[1] = a_y; assign av[2] = a_z;
	assign bv[0] = b_x; assign bv[1] = b_y; assign bv[2] = b_z;
	assign cv[0] = c_x; assign cv[1] = c_y; assign cv[2] = c_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], in_valid};
		end
	end

	always_comb begin
		for (int i = 0; i < tfn_pkg::LANES; i++) begin
			n_c[i] = tfn_pkg::CROSS_W'(p_s2[i]) - tfn_pkg::CROSS_W'(r_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < tfn_pkg::LANES; i++) begin
				u_s1[i] <= tfn_pkg::DIFF_W'(bv[i]) - tfn_pkg::DIFF_W'(av[i]);
				v_s1[i] <= tfn_pkg::DIFF_W'(cv[i]) - tfn_pkg::DIFF_W'(av[i]);
				p_s2[i] <= tfn_pkg::PROD_W'(u_s1[(i+1)%3]) * tfn_pkg::PROD_W'(v_s1[(i+2)%3]);
				r_s2[i] <= tfn_pkg::PROD_W'(u_s1[(i+2)%3]) * tfn_pkg::PROD_W'(v_s1[(i+1)%3]);
				neg_s3[i] <= n_c[i][tfn_pkg::CROSS_W-1];
				mag_s3[i] <= n_c[i][tfn_pkg::CROSS_W-1] ? tfn_pkg::MAG_W'(-n_c[i])
					: tfn_pkg::MAG_W'(n_c[i]);
				hh_s4[i] <= mag_s3[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W]
					* mag_s3[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W];
				hl_s4[i] <= mag_s3[i][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W]
					* mag_s3[i][tfn_pkg::HALF_W-1:0];
				ll_s4[i] <= mag_s3[i][tfn_pkg::HALF_W-1:0] * mag_s3[i][tfn_pkg::HALF_W-1:0];
				sq_s5[i] <= (tfn_pkg::SQ_W'(hh_s4[i]) << tfn_pkg::MAG_W)
					+ (tfn_pkg::SQ_W'(hl_s4[i]) << (tfn_pkg::HALF_W + 1))
					+ tfn_pkg::SQ_W'(ll_s4[i]);
				sq_s6[i] <= sq_s5[i];
			end
			neg_s4 <= neg_s3;
			neg_s5 <= neg_s4;
			neg_s6 <= neg_s5;
			sum_s6 <= tfn_pkg::SUM_W'(sq_s5[0]) + tfn_pkg::SUM_W'(sq_s5[1])
				+ tfn_pkg::SUM_W'(sq_s5[2]);
		end
	end

	always_comb begin
		out_data.deg = (sum_s6 == '0);
		out_data.neg = neg_s6;
		out_data.sb  = tfn_pkg::TW'(sum_s6) << (2 * tfn_pkg::NORMAL_FRAC_BITS);
		for (int i = 0; i < tfn_pkg::LANES; i++) begin
			out_data.d[i]  = tfn_pkg::TW'(sq_s6[i]) << (2 * tfn_pkg::NORMAL_FRAC_BITS);
			out_data.rb[i] = '0;
			out_data.q[i]  = '0;
		end
	end

	assign out_valid = vld_q[5];

endmodule

// ----- src/tfn_cell.sv -----
// one normalization cell: decides one quotient bit for each of three lanes
// depends on tfn_pkg; cells are chained, most significant bit first
module tfn_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  tfn_pkg::cell_t in_data,
	output logic           out_valid,
	output tfn_pkg::cell_t out_data
);

	tfn_pkg::wide_t            t     [tfn_pkg::LANES];
	logic [tfn_pkg::LANES-1:0] take;
	tfn_pkg::cell_t            nxt;
	tfn_pkg::cell_t            data_q;
	logic                      valid_q;

	// t = (q*S << (b+1)) + (S << 2b); accept the bit when t fits in the remainder
	always_comb begin
		nxt.deg = in_data.deg;
		nxt.neg = in_data.neg;
		nxt.sb  = in_data.sb >> 2;
		for (int i = 0; i < tfn_pkg::LANES; i++) begin
			t[i]       = in_data.rb[i] + in_data.sb;
			take[i]    = (t[i] <= in_data.d[i]);
			nxt.d[i]   = take[i] ? in_data.d[i] - t[i] : in_data.d[i];
			nxt.rb[i]  = (take[i] ? in_data.rb[i] + (in_data.sb << 1) : in_data.rb[i]) >> 1;
			nxt.q[i]   = {in_data.q[i][tfn_pkg::Q_W-2:0], take[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ----- src/triangle_face_normal.sv -----
// top level of the triangle unit normal engine
// depends on tfn_pkg, tfn_front and tfn_cell
//
// channel   direction   handshake                 payload
// tri       in          tri_valid / tri_stall     a_x .. c_z, 24 bit signed
// norm      out         norm_valid / norm_stall   normal_x/y/z 32 bit signed, degenerate
//
// one transaction per cycle while no stalled result holds the pipeline (6 front stages, 31 cells, output)
// each cell settles one bit of all three components, so the cell row sets the latency
// a stalled result holds the whole pipeline; tri_stall follows norm_stall while norm_valid is high
// reset clears the valid bits only
module triangle_face_normal (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   tri_valid,
	output logic                                   tri_stall,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  a_x,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  a_y,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  a_z,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  b_x,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  b_y,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  b_z,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  c_x,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  c_y,
	input  logic signed [tfn_pkg::COORD_BITS-1:0]  c_z,
	output logic                                   norm_valid,
	input  logic                                   norm_stall,
	output logic signed [tfn_pkg::NORMAL_W-1:0]    normal_x,
	output logic signed [tfn_pkg::NORMAL_W-1:0]    normal_y,
	output logic signed [tfn_pkg::NORMAL_W-1:0]    normal_z,
	output logic                                   degenerate
);

	logic                          en;
	logic                          vld   [tfn_pkg::CELLS+1];
	tfn_pkg::cell_t                cdata [tfn_pkg::CELLS+1];
	logic signed [tfn_pkg::NORMAL_W-1:0] res [tfn_pkg::LANES];
	logic signed [tfn_pkg::NORMAL_W-1:0] res_q [tfn_pkg::LANES];
	logic                          deg_q;
	logic                          valid_q;

	assign en        = !(valid_q && norm_stall);
	assign tri_stall = valid_q && norm_stall;

	tfn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (tri_valid && !tri_stall),
		.a_x       (a_x),
		.a_y       (a_y),
		.a_z       (a_z),
		.b_x       (b_x),
		.b_y       (b_y),
		.b_z       (b_z),
		.c_x       (c_x),
		.c_y       (c_y),
		.c_z       (c_z),
		.out_valid (vld[0]),
		.out_data  (cdata[0])
	);

	for (genvar g = 0; g < tfn_pkg::CELLS; g++) begin : g_cell
		tfn_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld[g]),
			.in_data   (cdata[g]),
			.out_valid (vld[g+1]),
			.out_data  (cdata[g+1])
		);
	end

	always_comb begin
		for (int i = 0; i < tfn_pkg::LANES; i++) begin
			if (cdata[tfn_pkg::CELLS].deg) begin
				res[i] = '0;
			end else if (cdata[tfn_pkg::CELLS].neg[i]) begin
				res[i] = -tfn_pkg::NORMAL_W'(cdata[tfn_pkg::CELLS].q[i]);
			end else begin
				res[i] = tfn_pkg::NORMAL_W'(cdata[tfn_pkg::CELLS].q[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= vld[tfn_pkg::CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res;
			deg_q <= cdata[tfn_pkg::CELLS].deg;
		end
	end

	assign norm_valid = valid_q;
	assign normal_x   = res_q[0];
	assign normal_y   = res_q[1];
	assign normal_z   = res_q[2];
	assign degenerate = deg_q;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate result with nonzero normal");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && !degenerate |->
			normal_x <= tfn_pkg::NORM_ONE && normal_x >= -tfn_pkg::NORM_ONE &&
			normal_y <= tfn_pkg::NORM_ONE && normal_y >= -tfn_pkg::NORM_ONE &&
			normal_z <= tfn_pkg::NORM_ONE && normal_z >= -tfn_pkg::NORM_ONE)
		else $error("normal component beyond unit length");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		tri_stall |-> norm_valid && norm_stall)
		else $error("input stalled without a held result");

endmodule
